[rtl/radial_explosion_force_core_macros.svh]
// Assertion macros shared by the radial explosion force RTL.
`ifndef RADIAL_EXPLOSION_FORCE_CORE_MACROS_SVH
`define RADIAL_EXPLOSION_FORCE_CORE_MACROS_SVH

// Same-cycle implication check.
`define REXF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define REXF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rexf_pkg.sv]
// ----------------------------------------------------------------------------
// rexf_pkg
// Shared constants and types of the radial explosion force core.
// ----------------------------------------------------------------------------
package rexf_pkg;

   localparam int COORD_W    = 16;
   localparam int VEC_W      = 3 * COORD_W;
   localparam int COEF_BITS  = 16;
   localparam int COEF_W     = COEF_BITS + 1;
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_BITS;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = VEC_W;
   localparam int MODE_W     = 2;

   // Iterations of a shared step folded into one pipeline stage.
   localparam int SQRT_STEPS_PER_STAGE = 2;
   localparam int DIV_STEPS_PER_STAGE  = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BLAST_CENTER   = 3'd0,
      CSR_FALLOFF_RADIUS = 3'd1,
      CSR_FORCE_OUTER    = 3'd2,
      CSR_FORCE_INNER    = 3'd3,
      CSR_FALLOFF_MODE   = 3'd4
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR = 2'd0,
      MODE_SQUARE = 2'd1,
      MODE_CUBIC  = 2'd2,
      MODE_SQRT   = 2'd3
   } falloff_mode_type;

endpackage

[rtl/rexf_isqrt_pipe.sv]
// ----------------------------------------------------------------------------
// rexf_isqrt_pipe
// Pipelined integer square root, digit by digit, with a sideband field.
// ----------------------------------------------------------------------------
module rexf_isqrt_pipe import rexf_pkg::*; #(
   parameter int RAD_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     ce,
   input  logic                     in_vld,
   input  logic [RAD_W-1:0]         in_rad,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_vld,
   output logic [(RAD_W+1)/2-1:0]   out_root,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int PAD_W  = RAD_W + (RAD_W % 2);
   localparam int ROOT_W = PAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int SPS    = SQRT_STEPS_PER_STAGE;
   localparam int STG    = (ROOT_W + SPS - 1) / SPS;

   logic [PAD_W-1:0]  rad_ff  [STG];
   logic [REM_W-1:0]  rem_ff  [STG];
   logic [ROOT_W-1:0] root_ff [STG];
   logic [SIDE_W-1:0] side_ff [STG];
   logic              vld_ff  [STG];

   for (genvar s = 0; s < STG; s++) begin : g_stage
      logic [PAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      logic [PAD_W-1:0]  rad_in;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [REM_W-1:0]  trial;

      // Stage input comes from the ports or from the previous stage.
      if (s == 0) begin : g_first
         assign rad_src  = PAD_W'(in_rad);
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      // Each step brings down two radicand bits and decides one root bit.
      always_comb begin
         rad_in  = rad_src;
         rem_in  = rem_src;
         root_in = root_src;
         trial   = '0;
         for (int j = 0; j < SPS; j++) begin
            if (s * SPS + j < ROOT_W) begin
               rem_in = {rem_in[REM_W-3:0], rad_in[PAD_W-1 -: 2]};
               rad_in = rad_in << 2;
               trial  = {1'b0, root_in, 2'b01};
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[ROOT_W-2:0], 1'b1};
               end else begin
                  root_in = {root_in[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (ce) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[STG-1];
   assign out_root = root_ff[STG-1];
   assign out_side = side_ff[STG-1];

endmodule

[rtl/rexf_div_pipe.sv]
// ----------------------------------------------------------------------------
// rexf_div_pipe
// Pipelined restoring divider for (num << (Q_W-1)) / den with num <= den.
// ----------------------------------------------------------------------------
module rexf_div_pipe import rexf_pkg::*; #(
   parameter int DEN_W  = 16,
   parameter int Q_W    = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_vld,
   input  logic [DEN_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [Q_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = DEN_W + 1;
   localparam int SPS   = DIV_STEPS_PER_STAGE;
   localparam int STG   = (Q_W + SPS - 1) / SPS;

   logic [REM_W-1:0]  rem_ff  [STG];
   logic [Q_W-1:0]    quo_ff  [STG];
   logic [SIDE_W-1:0] side_ff [STG];
   logic              vld_ff  [STG];

   for (genvar s = 0; s < STG; s++) begin : g_stage
      logic [REM_W-1:0]  rem_src;
      logic [Q_W-1:0]    quo_src;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      logic [REM_W-1:0]  rem_in;
      logic [Q_W-1:0]    quo_in;

      if (s == 0) begin : g_first
         assign rem_src  = {1'b0, in_num};
         assign quo_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      // The first step compares the numerator as is; later steps shift in a zero.
      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         for (int j = 0; j < SPS; j++) begin
            if (s * SPS + j < Q_W) begin
               if (s * SPS + j > 0) begin
                  rem_in = rem_in << 1;
               end
               if (rem_in >= {1'b0, den}) begin
                  rem_in = rem_in - {1'b0, den};
                  quo_in = {quo_in[Q_W-2:0], 1'b1};
               end else begin
                  quo_in = {quo_in[Q_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (ce) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[STG-1];
   assign out_quo  = quo_ff[STG-1];
   assign out_side = side_ff[STG-1];

endmodule

[rtl/radial_explosion_force_core.sv]
// ----------------------------------------------------------------------------
// radial_explosion_force_core
// Radial falloff force: blends inner and outer force by distance from center.
// ----------------------------------------------------------------------------
// The core takes one body position per cycle while no result waits on the output,
// and returns one force per position. The pipeline has three stages for the offset and
// the sum of squares, nine for the length square root, one for the numerator,
// nine for the coefficient divider, one to form the coefficient, nine for the
// square root falloff, and four for shaping, blending and saturation. The
// whole pipeline advances together and holds while a result waits on the
// output. The user must write configuration only while no transaction is in flight; the core does not enforce it.
`include "radial_explosion_force_core_macros.svh"

module radial_explosion_force_core import rexf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [COORD_W-1:0] rsp_force_x,
   output logic signed [COORD_W-1:0] rsp_force_y,
   output logic signed [COORD_W-1:0] rsp_force_z,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SUM_W = 2 * COORD_W + 2;
   localparam int LEN_W = SUM_W / 2;
   localparam int PRD_W = COORD_W + COEF_W + 1;
   localparam int ACC_W = PRD_W + 1;
   localparam int FRC_W = ACC_W - COEF_BITS;
   localparam logic signed [FRC_W-1:0] FRC_MAX = FRC_W'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [FRC_W-1:0] FRC_MIN = -FRC_W'(1 << (COORD_W - 1));

   // Configuration registers.
   logic [VEC_W-1:0]   center_ff, outer_ff, inner_ff;
   logic [COORD_W-1:0] radius_ff;
   falloff_mode_type   mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= COORD_W'(64);
         outer_ff  <= '0;
         inner_ff  <= '0;
         mode_ff   <= MODE_LINEAR;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BLAST_CENTER:   center_ff <= csr_wdata;
            CSR_FALLOFF_RADIUS: radius_ff <= csr_wdata[COORD_W-1:0];
            CSR_FORCE_OUTER:    outer_ff  <= csr_wdata;
            CSR_FORCE_INNER:    inner_ff  <= csr_wdata;
            CSR_FALLOFF_MODE:   mode_ff   <= falloff_mode_type'(csr_wdata[MODE_W-1:0]);
            default: ;
         endcase
      end
   end

   // Global advance: the pipeline moves unless the output holds a waiting result.
   logic ce;
   logic out_vld_ff;
   assign ce        = !out_vld_ff || rsp_ready;
   assign req_ready = ce;

   // Stage 1: absolute offsets from the center and the far test.
   logic [COORD_W-1:0] pos [3];
   logic [COORD_W-1:0] mag_in [3];
   logic [COORD_W-1:0] mag_ff [3];
   logic               far_in, far_ff, s1_vld_ff;
   logic signed [COORD_W:0] dif [3];

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   always_comb begin
      far_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dif[i] = $signed({pos[i][COORD_W-1], pos[i]})
                - $signed({center_ff[i*COORD_W+COORD_W-1], center_ff[i*COORD_W +: COORD_W]});
         mag_in[i] = dif[i][COORD_W] ? COORD_W'(-dif[i]) : dif[i][COORD_W-1:0];
         if (mag_in[i] >= radius_ff) begin
            far_in = 1'b1;
         end
      end
   end

   // Stage 2: squares.  Stage 3: sum of squares.
   logic [2*COORD_W-1:0] sq_ff [3];
   logic                 far2_ff, s2_vld_ff;
   logic [SUM_W-1:0]     sum_in, sum_ff;
   logic                 far3_ff, s3_vld_ff;

   assign sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (ce) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            sq_ff[i]  <= mag_ff[i] * mag_ff[i];
         end
         far_ff  <= far_in;
         far2_ff <= far_ff;
         sum_ff  <= sum_in;
         far3_ff <= far2_ff;
      end
   end

   // Length of the offset.
   logic             len_vld;
   logic [LEN_W-1:0] len;
   logic             len_far;

   rexf_isqrt_pipe #(.RAD_W(SUM_W), .SIDE_W(1)) u_len_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_vld   (s3_vld_ff),
      .in_rad   (sum_ff),
      .in_side  (far3_ff),
      .out_vld  (len_vld),
      .out_root (len),
      .out_side (len_far)
   );

   // Stage 4: numerator radius - length, or zero at or beyond the radius.
   logic               zero_in, zero_ff, s4_vld_ff;
   logic [COORD_W-1:0] num_in, num_ff;

   always_comb begin
      zero_in = len_far || (len >= LEN_W'(radius_ff));
      num_in  = zero_in ? '0 : COORD_W'(LEN_W'(radius_ff) - len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (ce) begin
         s4_vld_ff <= len_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         zero_ff <= zero_in;
         num_ff  <= num_in;
      end
   end

   // Linear coefficient (radius - length) / radius in Q1.16.
   logic              quo_vld, quo_zero;
   logic [COEF_W-1:0] quo;

   rexf_div_pipe #(.DEN_W(COORD_W), .Q_W(COEF_W), .SIDE_W(1)) u_coef_div (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_vld   (s4_vld_ff),
      .in_num   (num_ff),
      .den      (radius_ff),
      .in_side  (zero_ff),
      .out_vld  (quo_vld),
      .out_quo  (quo),
      .out_side (quo_zero)
   );

   // Stage 5: linear coefficient, forced to zero where no division applies.
   logic [COEF_W-1:0] lin_in, lin_ff;
   logic              s5_vld_ff;

   assign lin_in = quo_zero ? '0 : quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (ce) begin
         s5_vld_ff <= quo_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         lin_ff <= lin_in;
      end
   end

   // Square root falloff; the linear coefficient rides along as sideband.
   logic              rt_vld;
   logic [COEF_W-1:0] rt_root, rt_lin;

   rexf_isqrt_pipe #(.RAD_W(COEF_W + COEF_BITS), .SIDE_W(COEF_W)) u_coef_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_vld   (s5_vld_ff),
      .in_rad   ({lin_ff, {COEF_BITS{1'b0}}}),
      .in_side  (lin_ff),
      .out_vld  (rt_vld),
      .out_root (rt_root),
      .out_side (rt_lin)
   );

   // Stage 6: square.  Stage 7: cube and mode select.
   logic [COEF_W-1:0]   c6_ff, rt6_ff, sq6_ff, sq_in;
   logic [2*COEF_W-1:0] sq_prod, cube_prod;
   logic                s6_vld_ff;
   logic [COEF_W-1:0]   cube_in, coef_in, coef_ff;
   logic                s7_vld_ff;

   assign sq_prod   = rt_lin * rt_lin;
   assign sq_in     = COEF_W'(sq_prod >> COEF_BITS);
   assign cube_prod = sq6_ff * c6_ff;
   assign cube_in   = COEF_W'(cube_prod >> COEF_BITS);

   always_comb begin
      case (mode_ff)
         MODE_SQUARE: coef_in = sq6_ff;
         MODE_CUBIC:  coef_in = cube_in;
         MODE_SQRT:   coef_in = rt6_ff;
         default:     coef_in = c6_ff;
      endcase
      if (coef_in > COEF_ONE) begin
         coef_in = COEF_ONE;
      end
   end

   // Stage 8: weighted products.  Stage 9: rounded sum, saturated, to the output.
   logic signed [PRD_W-1:0]  po_ff [3];
   logic signed [PRD_W-1:0]  pi_ff [3];
   logic                     s8_vld_ff;
   logic [COEF_W-1:0]        wout;
   logic signed [ACC_W-1:0]  acc [3];
   logic signed [FRC_W-1:0]  frc [3];
   logic [COORD_W-1:0]       frc_in [3];
   logic [COORD_W-1:0]       frc_ff [3];

   assign wout = COEF_ONE - coef_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ACC_W'(po_ff[i]) + ACC_W'(pi_ff[i])
                + $signed(ACC_W'(COEF_ONE >> 1));
         frc[i] = FRC_W'(acc[i] >>> COEF_BITS);
         if (frc[i] > FRC_MAX) begin
            frc_in[i] = FRC_MAX[COORD_W-1:0];
         end else if (frc[i] < FRC_MIN) begin
            frc_in[i] = FRC_MIN[COORD_W-1:0];
         end else begin
            frc_in[i] = frc[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (ce) begin
         s6_vld_ff  <= rt_vld;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= s7_vld_ff;
         out_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         c6_ff   <= rt_lin;
         rt6_ff  <= rt_root;
         sq6_ff  <= sq_in;
         coef_ff <= coef_in;
         for (int i = 0; i < 3; i++) begin
            po_ff[i] <= $signed(outer_ff[i*COORD_W +: COORD_W]) * $signed({1'b0, wout});
            pi_ff[i] <= $signed(inner_ff[i*COORD_W +: COORD_W]) * $signed({1'b0, coef_ff});
            frc_ff[i] <= frc_in[i];
         end
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_force_x = frc_ff[0];
   assign rsp_force_y = frc_ff[1];
   assign rsp_force_z = frc_ff[2];

   // A waiting result must stop new transactions from entering.
   `REXF_ASSERT_IMP(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input accepted while output stalled")
   // The shaped coefficient never exceeds one.
   `REXF_ASSERT_IMP(a_coef_bound, clock, reset, s7_vld_ff, coef_ff <= COEF_ONE, "coefficient above one")
   // A stall freezes the stage 5 and stage 8 valid bits.
   `REXF_ASSERT_NXT(a_stall_holds, clock, reset, !ce, $stable(s8_vld_ff) && $stable(s5_vld_ff), "pipeline moved during stall")

endmodule
